/* rtl/core/first_fit_region_allocator_assert.svh */
// Assertion macros for the first-fit region allocator checker.
`ifndef FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define FFRA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define FFRA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/ffra_pkg.sv */
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared widths, defaults and register codes of the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int unsigned MAX_REGIONS_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF   = 32;

  localparam int unsigned SIZE_W       = 32;  // request size and result address
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned PAGE_SHIFT_W = 5;

  localparam logic [PAGE_SHIFT_W-1:0] PAGE_SHIFT_RST = 5'd8;
  localparam logic [PAGE_SHIFT_W-1:0] PAGE_SHIFT_MIN = 5'd8;
  localparam logic [PAGE_SHIFT_W-1:0] PAGE_SHIFT_MAX = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_SHIFT = 1'b0,
    CFG_HEAP_START = 1'b1
  } cfg_idx_e;

endpackage

/* rtl/core/ffra_if.sv */
// ----------------------------------------------------------------------------
// ffra_req_if / ffra_res_if
// Valid/ready channels for allocation requests and allocation results.
// ----------------------------------------------------------------------------
interface ffra_req_if;
  import ffra_pkg::*;

  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] req_size;

  modport source (output valid, output req_size, input ready);
  modport sink   (input valid, input req_size, output ready);
endinterface

interface ffra_res_if;
  import ffra_pkg::*;

  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] grant_addr;
  logic              ok;

  modport source (output valid, output grant_addr, output ok, input ready);
  modport sink   (input valid, input grant_addr, input ok, output ready);
endinterface

/* rtl/core/first_fit_region_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit allocator over an ordered free-region table with heap growth.
// ----------------------------------------------------------------------------
//  channel   dir  payload                 transfer
//  req_i     in   req_size                valid & ready
//  res_o     out  grant_addr, ok          valid & ready
//  cfg       in   cfg_idx_i, cfg_data_i   cfg_we_i
//
//  Each request scans the table in order; an exact fit moves the entries
//  behind it up, a partial fit shrinks the entry, growth moves entries
//  down for a new head, and a failed growth or a new region used up at
//  once leaves it unchanged. Single-port table (registered read), one adder.
//  Reset clears the table count; heap top and page shift take their defaults.
//  req_i ready only when idle; DONE holds while the last result waits.
// ----------------------------------------------------------------------------
module first_fit_region_allocator #(
  parameter int unsigned MAX_REGIONS = ffra_pkg::MAX_REGIONS_DEF,
  parameter int unsigned ADDR_BITS   = ffra_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ffra_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ffra_req_if.sink                        req_i,
  ffra_res_if.source                      res_o
);
  import ffra_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_REGIONS);
  localparam int unsigned CW  = $clog2(MAX_REGIONS + 1);
  localparam int unsigned CW1 = CW + 1;
  localparam int unsigned AW  = ADDR_BITS;
  localparam int unsigned BW  = SIZE_W + 1;                 // rounded growth
  localparam int unsigned WW  = ((AW > BW) ? AW : BW) + 1;  // adder width

  typedef logic [AW-1:0] addr_t;
  typedef logic [WW-1:0] word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_UPD, S_ROUND, S_GROW, S_MV_RD, S_MV_WR, S_HEAD, S_DONE
  } state_e;

  state_e                  state_q;
  logic [SIZE_W-1:0]       size_q;
  logic [IW-1:0]           idx_q, k_q;
  logic                    mv_up_q;
  logic [CW-1:0]           count_q;
  addr_t                   heap_top_q, new_top_q, addr_q;
  logic                    ok_q;
  logic [PAGE_SHIFT_W-1:0] page_shift_q;
  logic [BW-1:0]           bytes_q;
  logic                    out_valid_q;
  addr_t                   res_addr_q;
  logic                    res_ok_q;

  // region table
  addr_t mem_start [MAX_REGIONS];
  addr_t mem_end   [MAX_REGIONS];
  addr_t rd_start_q, rd_end_q;

  logic          rd_en, mem_we;
  logic [IW-1:0] rd_addr, wr_addr;
  addr_t         wr_start, wr_end;

  // shared adder
  word_t alu_a, alu_b, alu_y;
  logic  alu_sub;

  logic [PAGE_SHIFT_W-1:0] sh;
  logic [BW-1:0]           mask, bytes_d;
  addr_t                   len;
  logic                    fit, exact, ovf, grow_ok, exact_grow;

  always_comb begin
    if (page_shift_q < PAGE_SHIFT_MIN)      sh = PAGE_SHIFT_MIN;
    else if (page_shift_q > PAGE_SHIFT_MAX) sh = PAGE_SHIFT_MAX;
    else                                    sh = page_shift_q;
    mask = ~({BW{1'b1}} << sh);
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_CMP: begin
        alu_a   = WW'(rd_end_q);
        alu_b   = WW'(rd_start_q);
        alu_sub = 1'b1;
      end
      S_UPD: begin
        alu_a = WW'(rd_start_q);
        alu_b = WW'(size_q);
      end
      S_ROUND: begin
        alu_a = WW'(size_q);
        alu_b = WW'(mask);
      end
      S_GROW: begin
        alu_a = WW'(heap_top_q);
        alu_b = WW'(bytes_q);
      end
      S_HEAD: begin
        alu_a = WW'(heap_top_q);
        alu_b = WW'(size_q);
      end
      default: ;
    endcase
    alu_y = alu_a + (alu_b ^ {WW{alu_sub}}) + WW'(alu_sub);
  end

  assign len        = AW'(alu_y);
  assign fit        = WW'(size_q) <= WW'(len);
  assign exact      = WW'(size_q) == WW'(len);
  assign bytes_d    = BW'(alu_y) & ~mask;
  assign ovf        = (alu_y >> AW) != '0;
  assign grow_ok    = (bytes_q != '0) && (count_q < CW'(MAX_REGIONS)) && !ovf;
  assign exact_grow = bytes_q == BW'(size_q);

  // table port control
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = idx_q;
    mem_we   = 1'b0;
    wr_addr  = k_q;
    wr_start = rd_start_q;
    wr_end   = rd_end_q;
    unique case (state_q)
      S_RD: rd_en = 1'b1;
      S_MV_RD: begin
        rd_en   = 1'b1;
        rd_addr = mv_up_q ? (k_q + IW'(1)) : (k_q - IW'(1));
      end
      S_MV_WR: mem_we = 1'b1;
      S_UPD: begin
        mem_we   = 1'b1;
        wr_addr  = idx_q;
        wr_start = AW'(alu_y);
      end
      S_HEAD: begin
        mem_we   = 1'b1;
        wr_addr  = '0;
        wr_start = AW'(alu_y);
        wr_end   = new_top_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_start[wr_addr] <= wr_start;
      mem_end[wr_addr]   <= wr_end;
    end
    if (rd_en) begin
      rd_start_q <= mem_start[rd_addr];
      rd_end_q   <= mem_end[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      size_q       <= '0;
      idx_q        <= '0;
      k_q          <= '0;
      mv_up_q      <= 1'b0;
      count_q      <= '0;
      heap_top_q   <= '0;
      new_top_q    <= '0;
      addr_q       <= '0;
      ok_q         <= 1'b0;
      page_shift_q <= PAGE_SHIFT_RST;
      bytes_q      <= '0;
      out_valid_q  <= 1'b0;
      res_addr_q   <= '0;
      res_ok_q     <= 1'b0;
    end else begin
      if (out_valid_q && res_o.ready && (state_q != S_DONE)) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            size_q  <= req_i.req_size;
            idx_q   <= '0;
            state_q <= (count_q == '0) ? S_ROUND : S_RD;
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (fit) begin
            addr_q <= rd_start_q;
            ok_q   <= 1'b1;
            if (exact) begin
              // close the gap: entries behind move up one place
              count_q <= count_q - CW'(1);
              k_q     <= idx_q;
              mv_up_q <= 1'b1;
              state_q <= (CW1'(idx_q) + CW1'(1) < CW1'(count_q)) ? S_MV_RD : S_DONE;
            end else begin
              state_q <= S_UPD;
            end
          end else begin
            idx_q   <= idx_q + IW'(1);
            state_q <= (CW1'(idx_q) + CW1'(1) >= CW1'(count_q)) ? S_ROUND : S_RD;
          end
        end
        S_UPD: state_q <= S_DONE;
        S_ROUND: begin
          bytes_q <= bytes_d;
          state_q <= S_GROW;
        end
        S_GROW: begin
          if (grow_ok) begin
            new_top_q <= AW'(alu_y);
            addr_q    <= heap_top_q;
            ok_q      <= 1'b1;
            if (exact_grow) begin
              // new head region would be used up at once: table unchanged
              heap_top_q <= AW'(alu_y);
              state_q    <= S_DONE;
            end else begin
              count_q <= count_q + CW'(1);
              k_q     <= IW'(count_q);
              mv_up_q <= 1'b0;
              state_q <= (count_q != '0) ? S_MV_RD : S_HEAD;
            end
          end else begin
            addr_q  <= '0;
            ok_q    <= 1'b0;
            state_q <= S_DONE;
          end
        end
        S_MV_RD: state_q <= S_MV_WR;
        S_MV_WR: begin
          if (mv_up_q) begin
            // count_q already holds the shortened table length
            k_q     <= k_q + IW'(1);
            state_q <= (CW1'(k_q) + CW1'(1) < CW1'(count_q)) ? S_MV_RD : S_DONE;
          end else begin
            k_q     <= k_q - IW'(1);
            state_q <= (k_q == IW'(1)) ? S_HEAD : S_MV_RD;
          end
        end
        S_HEAD: begin
          heap_top_q <= new_top_q;
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || res_o.ready) begin
            res_addr_q  <= addr_q;
            res_ok_q    <= ok_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PAGE_SHIFT: page_shift_q <= PAGE_SHIFT_W'(cfg_data_i);
          CFG_HEAP_START: heap_top_q   <= AW'(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign res_o.valid      = out_valid_q;
  assign res_o.grant_addr = SIZE_W'(res_addr_q);
  assign res_o.ok         = res_ok_q;

endmodule

/* rtl/core/ffra_checker.sv */
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level checks on the first-fit region allocator, bound to its top level.
// ----------------------------------------------------------------------------
`include "first_fit_region_allocator_assert.svh"

module ffra_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [ffra_pkg::SIZE_W-1:0] res_addr_i,
  input logic                        res_ok_i
);
  import ffra_pkg::*;

  logic              res_stall;
  logic              req_xfer;
  logic [SIZE_W:0]   res_word;

  assign res_stall = res_valid_i && !res_ready_i;
  assign req_xfer  = req_valid_i && req_ready_i;
  assign res_word  = {res_addr_i, res_ok_i};

  // a stalled result holds
  `FFRA_ASSERT(a_res_hold, clk_i, rst_ni, res_stall |=> res_valid_i && $stable(res_word), "stalled result changed")

  // failures report address zero
  `FFRA_ASSERT(a_fail_zero, clk_i, rst_ni, res_valid_i && !res_ok_i |-> res_addr_i == '0, "failed with non-zero address")

  // one request at a time: busy straight after a request transfer
  `FFRA_ASSERT(a_busy_after_req, clk_i, rst_ni, req_xfer |=> !req_ready_i, "ready right after a request transfer")

  // no result while reset is asserted
  `FFRA_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !res_valid_i, "result valid during reset")

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_addr_i  (res_o.grant_addr),
  .res_ok_i    (res_o.ok)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit region allocator. Requests are driven
// on the valid/ready input channel, results taken from the output channel
// with random back-pressure, and every result is compared with a local copy
// of the free-region table, the heap top and the page-rounding rules.
// ----------------------------------------------------------------------------
module testbench;
  import ffra_pkg::*;

  localparam int unsigned NUM_REGIONS = MAX_REGIONS_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned HOLDOFF_AFTER = 150;
  localparam logic [63:0] ADDR_TOP = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [SIZE_W-1:0] addr;
    logic              ok;
  } alloc_result_t;

  // Mirror of the region table; predicts each allocation and checks results.
  class alloc_tracker;
    logic [SIZE_W-1:0]       region_lo [NUM_REGIONS];
    logic [SIZE_W-1:0]       region_hi [NUM_REGIONS];
    int unsigned             region_cnt;
    logic [SIZE_W-1:0]       heap_top;
    logic [PAGE_SHIFT_W-1:0] page_shift;
    alloc_result_t           expected_q [$];
    int unsigned             errors;
    int unsigned             requests_seen;

    function new();
      region_cnt    = 0;
      heap_top      = '0;
      page_shift    = PAGE_SHIFT_RST;
      errors        = 0;
      requests_seen = 0;
    endfunction

    function logic [SIZE_W-1:0] region_len(int unsigned i);
      return region_hi[i] - region_lo[i];
    endfunction

    function int unsigned eff_shift();
      if (page_shift < PAGE_SHIFT_MIN) return 32'(PAGE_SHIFT_MIN);
      if (page_shift > PAGE_SHIFT_MAX) return 32'(PAGE_SHIFT_MAX);
      return 32'(page_shift);
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PAGE_SHIFT: page_shift = data[PAGE_SHIFT_W-1:0];
        CFG_HEAP_START: heap_top = data;
        default: ;
      endcase
    endfunction

    // Serve size bytes from entry i (known to fit); exact fit closes the gap.
    function logic [SIZE_W-1:0] carve(int unsigned i, logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] start;
      start = region_lo[i];
      if (region_len(i) == size) begin
        for (int k = i; k + 1 < region_cnt; k++) begin
          region_lo[k] = region_lo[k+1];
          region_hi[k] = region_hi[k+1];
        end
        region_cnt--;
      end else begin
        region_lo[i] = start + size;
      end
      return start;
    endfunction

    function void note_request(logic [SIZE_W-1:0] size);
      alloc_result_t res;
      int            hit;
      int unsigned   sh;
      logic [63:0]   pages;
      logic [63:0]   bytes;
      res = '0;
      hit = -1;
      requests_seen++;
      for (int i = 0; i < region_cnt && hit < 0; i++) begin
        if (size <= region_len(i)) hit = i;
      end
      if (hit >= 0) begin
        res.addr = carve(hit, size);
        res.ok   = 1'b1;
      end else begin
        sh    = eff_shift();
        pages = ({32'b0, size} + (64'd1 << sh) - 64'd1) >> sh;
        bytes = pages << sh;
        if (bytes != 0 && region_cnt < NUM_REGIONS && bytes <= ADDR_TOP - {32'b0, heap_top})
        begin
          for (int k = region_cnt; k > 0; k--) begin
            region_lo[k] = region_lo[k-1];
            region_hi[k] = region_hi[k-1];
          end
          region_lo[0] = heap_top;
          region_hi[0] = heap_top + bytes[SIZE_W-1:0];
          region_cnt++;
          heap_top = heap_top + bytes[SIZE_W-1:0];
          res.addr = carve(0, size);
          res.ok   = 1'b1;
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [SIZE_W-1:0] addr, logic ok);
      alloc_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: grant_addr %h ok %b", addr, ok);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (want.addr !== addr) begin
        $error("grant_addr: expected %h, actual %h", want.addr, addr);
        errors++;
      end
      if (want.ok !== ok) begin
        $error("ok: expected %b, actual %b", want.ok, ok);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ffra_req_if req_if ();
  ffra_res_if res_if ();

  first_fit_region_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  alloc_tracker tracker;
  bit           quiet_phase = 1'b0;
  bit           holdoff_done = 1'b0;
  int unsigned  cycle_cnt = 0;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly back-to-back, sometimes a short gap, now and then a long gap.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Sizes biased towards exact fits, partial fits and forced growth.
  function automatic logic [SIZE_W-1:0] next_size();
    int unsigned       r;
    int unsigned       i;
    logic [SIZE_W-1:0] len;
    logic [SIZE_W-1:0] widest;
    r = $urandom_range(99, 0);
    if (r < 10) return '0;
    if (r < 35) return $urandom_range(2048, 1);
    if (r < 70 && tracker.region_cnt != 0) begin
      i   = $urandom_range(tracker.region_cnt - 1, 0);
      len = tracker.region_len(i);
      if (r < 55) return len;
      if (len > 1) return $urandom_range(len - 1, 1);
    end
    if (r < 85) begin
      // just past the widest free region, so the heap has to grow
      widest = '0;
      for (int k = 0; k < tracker.region_cnt; k++) begin
        if (tracker.region_len(k) > widest) widest = tracker.region_len(k);
      end
      return widest + $urandom_range(32'd1 << tracker.eff_shift(), 1);
    end
    if (r < 93) return $urandom_range(16, 1) << tracker.eff_shift();
    return $urandom();
  endfunction

  // Called just after a rising edge; returns at the edge of the transfer.
  task automatic send_request(logic [SIZE_W-1:0] size);
    int unsigned gap;
    gap = quiet_phase ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_size <= size;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_request(size);
  endtask

  task automatic wait_idle(int unsigned tail);
    req_if.valid <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_config(logic [PAGE_SHIFT_W-1:0] shift, logic [CFG_DATA_W-1:0] base);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom();
    data[PAGE_SHIFT_W-1:0] = shift;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PAGE_SHIFT;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_reg(CFG_PAGE_SHIFT, data);
    cfg_idx_i  <= CFG_HEAP_START;
    cfg_data_i <= base;
    @(posedge clk_i);
    tracker.write_reg(CFG_HEAP_START, base);
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off to back the block up.
  initial begin
    int unsigned stall;
    stall = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) tracker.check_result(res_if.grant_addr, res_if.ok);
      if (!holdoff_done && tracker.requests_seen >= HOLDOFF_AFTER) begin
        holdoff_done = 1'b1;
        res_if.ready <= 1'b0;
        for (int n = 0; n < HOLDOFF_CYCLES; n++) @(posedge clk_i);
      end else if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
        if (!quiet_phase && $urandom_range(3, 0) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    logic [PAGE_SHIFT_W-1:0] shift;
    logic [CFG_DATA_W-1:0]   base;
    tracker = new();
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_PAGE_SHIFT;
    cfg_data_i      <= '0;
    req_if.valid    <= 1'b0;
    req_if.req_size <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero size on an empty table, growth, zero size on a
    // non-empty head, exact fits, and a size whose rounding overflows.
    send_request(32'd0);
    send_request(32'd1);
    send_request(32'd0);
    send_request(32'd255);
    send_request(32'd256);
    send_request(32'd300);
    send_request(32'hFFFF_FFFF);
    send_request(32'd100);

    // Shift below range; heap grows to exactly the top address, then no room.
    wait_idle(4);
    write_config(5'd0, 32'hFFFF_FEFF);
    send_request(32'h0000_0100);
    send_request(32'd1);
    send_request(32'h0000_0200);
    send_request(32'd0);
    send_request(32'hFFFF_FFFF);

    // Shift above range with the heap top at the very end.
    wait_idle(4);
    write_config(5'd31, 32'hFFFF_FFFF);
    send_request(32'd1);
    send_request(32'h0000_0100);

    // Largest page size from the bottom of the address space.
    wait_idle(4);
    write_config(5'd16, 32'h0000_0000);
    send_request(32'h0001_0000);
    send_request(32'h0001_0001);
    send_request(32'h8000_0000);
    send_request(32'h8000_0001);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin shift = 5'd8;  base = 32'h0000_1000; end
        1: begin shift = 5'd12; base = $urandom_range(32'h00FF_FFFF, 0); end
        2: begin shift = 5'd7;  base = 32'h0000_0000; end
        3: begin shift = 5'd17; base = 32'h4000_0000; end
        4: begin shift = 5'd16; base = 32'hFFF0_0000; end
        default: begin
          shift = PAGE_SHIFT_W'($urandom_range(31, 0));
          base  = $urandom();
        end
      endcase
      wait_idle(4);
      quiet_phase = (phase == 2);
      write_config(shift, base);
      repeat (75) send_request(next_size());
    end

    wait_idle(100);
    if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
